[src/irq_vector_dispatcher_core_defines.svh]
// Assertion macros used by the checker file of the interrupt vector dispatcher.
`ifndef IRQ_VECTOR_DISPATCHER_CORE_DEFINES_SVH
`define IRQ_VECTOR_DISPATCHER_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define IVD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define IVD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/ivd_pkg.sv]
// Package with the request and response types and the codes of the interrupt vector dispatcher.
package ivd_pkg;

   localparam int LINE_W          = 6;
   localparam int ADDR_W          = 32;
   localparam int NUM_IRQ_DEF     = 64;
   localparam int QUEUE_DEPTH_DEF = 16;

   localparam logic [2:0] CMD_REGISTER   = 3'd0;
   localparam logic [2:0] CMD_UNREGISTER = 3'd1;
   localparam logic [2:0] CMD_RAISE      = 3'd2;
   localparam logic [2:0] CMD_DISPATCH   = 3'd3;
   localparam logic [2:0] CMD_LOOKUP     = 3'd4;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_NONE  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;
   localparam logic [1:0] STATUS_FULL  = 2'd3;

   typedef struct packed {
      logic [2:0]        cmd;
      logic [LINE_W-1:0] irq_line;
      logic [ADDR_W-1:0] handler_addr;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [LINE_W-1:0] out_irq;
      logic [ADDR_W-1:0] out_addr;
      logic              any_registered;
   } rsp_type;

endpackage

[src/irq_vector_dispatcher_core.sv]
// Top level of the interrupt vector dispatcher: vector table, pending queue and sequencer.
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_valid / req_ready  ivd_pkg::req_type (cmd, irq_line, handler_addr)
//   rsp_     out        rsp_valid / rsp_ready  ivd_pkg::rsp_type (status, out_irq, out_addr,
//                                                                 any_registered)
//
// One request at a time: every request but a popping dispatch passes the accept state ST_IDLE
// and a state that loads the output register (ST_TBL or ST_DONE; a table command reads the table
// in the first and writes back in the second); a dispatch that pops passes ST_IDLE (queue read),
// ST_FIFO (table read), then ST_TBL or ST_DONE. The single read port of each RAM sets this.
// After reset a clearing pass writes NUM_IRQ table entries, one per cycle, with req_ready low.
// A response waits in the output register while the next request is accepted; the sequencer
// stalls only when it has a new response and the output register is still occupied.
module irq_vector_dispatcher_core #(
   parameter int NUM_IRQ     = ivd_pkg::NUM_IRQ_DEF,
   parameter int QUEUE_DEPTH = ivd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ivd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ivd_pkg::rsp_type rsp_data
);

   localparam int LINE_W = ivd_pkg::LINE_W;
   localparam int ADDR_W = ivd_pkg::ADDR_W;
   localparam int ENT_W  = ADDR_W + 1;
   localparam int IDX_W  = $clog2(NUM_IRQ);
   localparam int Q_W    = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int VC_W   = $clog2(NUM_IRQ + 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FIFO,
      ST_TBL,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [2:0]        cmd_ff, cmd_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   ivd_pkg::rsp_type  res_ff, res_in;
   ivd_pkg::rsp_type  rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [Q_W-1:0]    head_ff, head_in;
   logic [Q_W-1:0]    tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [VC_W-1:0]   vcount_ff, vcount_in;
   logic [IDX_W-1:0]  clr_ff, clr_in;

   logic                    tbl_we, tbl_re;
   logic [IDX_W-1:0]        tbl_wa, tbl_ra;
   logic [ENT_W-1:0]        tbl_wd, tbl_rd;
   logic                    fifo_we, fifo_re;
   logic [LINE_W-1:0]       fifo_rd;

   logic [LINE_W+IDX_W-1:0] req_line_ext, pop_line_ext, cur_line_ext;
   logic [IDX_W-1:0]        req_idx, pop_idx, cur_idx;
   logic                    req_line_ok, pop_line_ok;
   logic                    out_free, ent_valid;
   ivd_pkg::rsp_type        tbl_res;

   // Line numbers are zero-extended, then cut to the table index width.
   assign req_line_ext = {{IDX_W{1'b0}}, req_data.irq_line};
   assign pop_line_ext = {{IDX_W{1'b0}}, fifo_rd};
   assign cur_line_ext = {{IDX_W{1'b0}}, line_ff};
   assign req_idx      = req_line_ext[IDX_W-1:0];
   assign pop_idx      = pop_line_ext[IDX_W-1:0];
   assign cur_idx      = cur_line_ext[IDX_W-1:0];
   assign req_line_ok  = 32'(req_data.irq_line) < 32'(NUM_IRQ);
   assign pop_line_ok  = 32'(fifo_rd) < 32'(NUM_IRQ);
   assign ent_valid    = tbl_rd[ADDR_W];
   assign out_free     = !rsp_valid_ff || rsp_ready;

   // Table entries hold the valid mark above the handler address.
   ivd_ram #(
      .WIDTH(ENT_W),
      .DEPTH(NUM_IRQ)
   ) u_table (
      .clock  (clock),
      .wr_en  (tbl_we),
      .wr_addr(tbl_wa),
      .wr_data(tbl_wd),
      .rd_en  (tbl_re),
      .rd_addr(tbl_ra),
      .rd_data(tbl_rd)
   );

   ivd_ram #(
      .WIDTH(LINE_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .wr_en  (fifo_we),
      .wr_addr(tail_ff),
      .wr_data(req_data.irq_line),
      .rd_en  (fifo_re),
      .rd_addr(head_ff),
      .rd_data(fifo_rd)
   );

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      line_in      = line_ff;
      addr_in      = addr_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      vcount_in    = vcount_ff;
      clr_in       = clr_ff;
      tbl_we       = 1'b0;
      tbl_wa       = cur_idx;
      tbl_wd       = '0;
      tbl_re       = 1'b0;
      tbl_ra       = req_idx;
      fifo_we      = 1'b0;
      fifo_re      = 1'b0;
      tbl_res      = '0;

      case (state_ff)
         ST_CLEAR: begin
            tbl_we = 1'b1;
            tbl_wa = clr_ff;
            tbl_wd = '0;
            clr_in = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(NUM_IRQ - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in                = req_data.cmd;
               line_in               = req_data.irq_line;
               addr_in               = req_data.handler_addr;
               res_in.status         = ivd_pkg::STATUS_OK;
               res_in.out_irq        = req_data.irq_line;
               res_in.out_addr       = '0;
               res_in.any_registered = (vcount_ff != '0);
               state_in              = ST_DONE;
               case (req_data.cmd)
                  ivd_pkg::CMD_REGISTER, ivd_pkg::CMD_UNREGISTER, ivd_pkg::CMD_LOOKUP: begin
                     if (req_line_ok) begin
                        tbl_re   = 1'b1;
                        state_in = ST_TBL;
                     end else begin
                        res_in.status = ivd_pkg::STATUS_NONE;
                     end
                  end
                  ivd_pkg::CMD_RAISE: begin
                     if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                        res_in.status = ivd_pkg::STATUS_FULL;
                     end else begin
                        fifo_we  = 1'b1;
                        tail_in  = (tail_ff == Q_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + Q_W'(1);
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  ivd_pkg::CMD_DISPATCH: begin
                     if (count_ff == '0) begin
                        res_in.status  = ivd_pkg::STATUS_EMPTY;
                        res_in.out_irq = '0;
                     end else begin
                        fifo_re  = 1'b1;
                        head_in  = (head_ff == Q_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + Q_W'(1);
                        count_in = count_ff - CNT_W'(1);
                        state_in = ST_FIFO;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FIFO: begin
            // The popped line replaces the request line; the table step treats it as a lookup.
            line_in        = fifo_rd;
            res_in.out_irq = fifo_rd;
            if (pop_line_ok) begin
               tbl_re   = 1'b1;
               tbl_ra   = pop_idx;
               state_in = ST_TBL;
            end else begin
               res_in.status = ivd_pkg::STATUS_NONE;
               state_in      = ST_DONE;
            end
         end
         ST_TBL: begin
            if (out_free) begin
               tbl_res.status   = ivd_pkg::STATUS_OK;
               tbl_res.out_irq  = line_ff;
               tbl_res.out_addr = '0;
               case (cmd_ff)
                  ivd_pkg::CMD_REGISTER: begin
                     tbl_we = 1'b1;
                     tbl_wd = {1'b1, addr_ff};
                     if (!ent_valid) begin
                        vcount_in = vcount_ff + VC_W'(1);
                     end
                  end
                  ivd_pkg::CMD_UNREGISTER: begin
                     if (ent_valid) begin
                        tbl_we    = 1'b1;
                        tbl_wd    = '0;
                        vcount_in = vcount_ff - VC_W'(1);
                     end else begin
                        tbl_res.status = ivd_pkg::STATUS_NONE;
                     end
                  end
                  default: begin
                     if (ent_valid) begin
                        tbl_res.out_addr = tbl_rd[ADDR_W-1:0];
                     end else begin
                        tbl_res.status = ivd_pkg::STATUS_NONE;
                     end
                  end
               endcase
               tbl_res.any_registered = (vcount_in != '0);
               rsp_in       = tbl_res;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         vcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         vcount_ff    <= vcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff  <= cmd_in;
      line_ff <= line_in;
      addr_ff <= addr_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[src/ivd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module ivd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // Read data holds until the next read is issued.
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/ivd_checker.sv]
// Port-level checker for the interrupt vector dispatcher, bound to the top level.
`include "irq_vector_dispatcher_core_defines.svh"

module ivd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ivd_pkg::rsp_type rsp_data
);

   // A stalled response must hold its contents.
   `IVD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response changed while stalled")

   // Acceptance moves the sequencer out of its idle state, so req_ready is low in the cycle after it.
   `IVD_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "request accepted in back-to-back cycles")

   // Only a successful dispatch or lookup carries a handler address.
   `IVD_ASSERT_NOW(a_addr_only_ok, clock, reset, rsp_valid && (rsp_data.status != ivd_pkg::STATUS_OK), rsp_data.out_addr == '0, "address reported with a failing status")

   // A dispatch on an empty queue reports line zero.
   `IVD_ASSERT_NOW(a_empty_line, clock, reset, rsp_valid && (rsp_data.status == ivd_pkg::STATUS_EMPTY), rsp_data.out_irq == '0, "empty queue reported a line")

endmodule

bind irq_vector_dispatcher_core ivd_checker u_ivd_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);

[tb/sv/tb_irq_vector_dispatcher_core.sv]
// Self-checking testbench for the interrupt vector dispatcher core with a shadow vector table.
`timescale 1ns / 100ps

module tb_irq_vector_dispatcher_core;

   localparam int LINE_W   = ivd_pkg::LINE_W;
   localparam int ADDR_W   = ivd_pkg::ADDR_W;
   localparam int N_IRQ    = ivd_pkg::NUM_IRQ_DEF;
   localparam int Q_DEPTH  = ivd_pkg::QUEUE_DEPTH_DEF;

   localparam logic [2:0] CMD_SPARE_A = 3'd5;
   localparam logic [2:0] CMD_SPARE_B = 3'd6;
   localparam logic [2:0] CMD_SPARE_C = 3'd7;

   localparam int ITEMS_PER_PHASE = 550;

   // Shadow copy of the vector table and pending queue; predicts each response.
   class vector_table_shadow;
      logic [ADDR_W-1:0] handler_addr_tbl [N_IRQ];
      bit                entry_valid [N_IRQ];
      int unsigned       registered_count;
      logic [LINE_W-1:0] pending_lines [$];
      ivd_pkg::rsp_type  due_rsp [$];
      int unsigned       mismatches;

      function bit has_handler(logic [LINE_W-1:0] line);
         return int'(line) < N_IRQ && entry_valid[line];
      endfunction

      function void apply_request(ivd_pkg::req_type r);
         ivd_pkg::rsp_type  p;
         logic [LINE_W-1:0] popped;
         p.status         = ivd_pkg::STATUS_OK;
         p.out_irq        = r.irq_line;
         p.out_addr       = '0;
         p.any_registered = 1'b0;
         case (r.cmd)
            ivd_pkg::CMD_REGISTER: begin
               if (int'(r.irq_line) < N_IRQ) begin
                  if (!entry_valid[r.irq_line]) begin
                     entry_valid[r.irq_line] = 1'b1;
                     registered_count++;
                  end
                  handler_addr_tbl[r.irq_line] = r.handler_addr;
               end else begin
                  p.status = ivd_pkg::STATUS_NONE;
               end
            end
            ivd_pkg::CMD_UNREGISTER: begin
               if (has_handler(r.irq_line)) begin
                  entry_valid[r.irq_line] = 1'b0;
                  registered_count--;
               end else begin
                  p.status = ivd_pkg::STATUS_NONE;
               end
            end
            ivd_pkg::CMD_RAISE: begin
               if (pending_lines.size() >= Q_DEPTH) begin
                  p.status = ivd_pkg::STATUS_FULL;
               end else begin
                  pending_lines.push_back(r.irq_line);
               end
            end
            ivd_pkg::CMD_DISPATCH: begin
               if (pending_lines.size() == 0) begin
                  p.status  = ivd_pkg::STATUS_EMPTY;
                  p.out_irq = '0;
               end else begin
                  popped    = pending_lines.pop_front();
                  p.out_irq = popped;
                  if (has_handler(popped)) begin
                     p.out_addr = handler_addr_tbl[popped];
                  end else begin
                     p.status = ivd_pkg::STATUS_NONE;
                  end
               end
            end
            ivd_pkg::CMD_LOOKUP: begin
               if (has_handler(r.irq_line)) begin
                  p.out_addr = handler_addr_tbl[r.irq_line];
               end else begin
                  p.status = ivd_pkg::STATUS_NONE;
               end
            end
            default: ;
         endcase
         p.any_registered = (registered_count != 0);
         due_rsp.push_back(p);
      endfunction

      function void check_response(ivd_pkg::rsp_type got);
         ivd_pkg::rsp_type want;
         if (due_rsp.size() == 0) begin
            $error("response with no request outstanding: %p", got);
            mismatches++;
            return;
         end
         want = due_rsp.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            mismatches++;
         end
         if (got.out_irq !== want.out_irq) begin
            $error("out_irq: expected %0d, actual %0d", want.out_irq, got.out_irq);
            mismatches++;
         end
         if (got.out_addr !== want.out_addr) begin
            $error("out_addr: expected 0x%08h, actual 0x%08h", want.out_addr, got.out_addr);
            mismatches++;
         end
         if (got.any_registered !== want.any_registered) begin
            $error("any_registered: expected %0b, actual %0b",
                   want.any_registered, got.any_registered);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return due_rsp.size();
      endfunction
   endclass

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   ivd_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   ivd_pkg::rsp_type rsp_data;

   int send_idle_pct = 20;
   int recv_idle_pct = 66;

   vector_table_shadow shadow = new();

   irq_vector_dispatcher_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Values read here are those before the edge, so this sees exactly what the block sampled.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) shadow.apply_request(req_data);
         if (rsp_valid && rsp_ready) shadow.check_response(rsp_data);
      end
   end

   function automatic ivd_pkg::req_type make_req(logic [2:0] cmd, logic [LINE_W-1:0] line,
                                                 logic [ADDR_W-1:0] addr);
      ivd_pkg::req_type r;
      r.cmd          = cmd;
      r.irq_line     = line;
      r.handler_addr = addr;
      return r;
   endfunction

   // Most lines come from a small set so that registered lines are raised and looked up often.
   function automatic logic [LINE_W-1:0] rand_line();
      if ($urandom_range(99) < 60) return LINE_W'($urandom_range(7));
      return LINE_W'($urandom_range(N_IRQ - 1));
   endfunction

   function automatic logic [ADDR_W-1:0] rand_addr();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return $urandom();
   endfunction

   function automatic ivd_pkg::req_type rand_req();
      int          pick;
      logic [2:0]  cmd;
      pick = $urandom_range(99);
      if (pick < 20) cmd = ivd_pkg::CMD_REGISTER;
      else if (pick < 35) cmd = ivd_pkg::CMD_UNREGISTER;
      else if (pick < 55) cmd = ivd_pkg::CMD_RAISE;
      else if (pick < 75) cmd = ivd_pkg::CMD_DISPATCH;
      else if (pick < 94) cmd = ivd_pkg::CMD_LOOKUP;
      else if (pick < 96) cmd = CMD_SPARE_A;
      else if (pick < 98) cmd = CMD_SPARE_B;
      else cmd = CMD_SPARE_C;
      return make_req(cmd, rand_line(), $urandom());
   endfunction

   // Leaves valid high on return so that a back-to-back request needs no second assignment.
   task automatic send_request(input ivd_pkg::req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (shadow.outstanding() != 0) @(posedge clock);
   endtask

   task automatic run_directed();
      send_request(make_req(ivd_pkg::CMD_LOOKUP, 6'd0, 32'h0));
      send_request(make_req(ivd_pkg::CMD_DISPATCH, 6'd0, 32'h0));
      send_request(make_req(ivd_pkg::CMD_UNREGISTER, 6'd5, 32'h0));
      send_request(make_req(ivd_pkg::CMD_REGISTER, 6'd0, 32'h0000_0000));
      send_request(make_req(ivd_pkg::CMD_REGISTER, 6'd63, 32'hFFFF_FFFF));
      send_request(make_req(ivd_pkg::CMD_REGISTER, 6'd63, 32'hA5A5_5A5A));
      send_request(make_req(ivd_pkg::CMD_LOOKUP, 6'd63, 32'hFFFF_FFFF));
      send_request(make_req(ivd_pkg::CMD_LOOKUP, 6'd0, 32'h0));
      send_request(make_req(ivd_pkg::CMD_RAISE, 6'd63, 32'h0));
      send_request(make_req(ivd_pkg::CMD_RAISE, 6'd0, 32'hFFFF_FFFF));
      send_request(make_req(ivd_pkg::CMD_RAISE, 6'd17, 32'h0));
      send_request(make_req(ivd_pkg::CMD_DISPATCH, 6'd0, 32'h0));
      send_request(make_req(ivd_pkg::CMD_DISPATCH, 6'd63, 32'h0));
      send_request(make_req(ivd_pkg::CMD_DISPATCH, 6'd0, 32'h0));
      send_request(make_req(ivd_pkg::CMD_UNREGISTER, 6'd0, 32'h0));
      send_request(make_req(ivd_pkg::CMD_LOOKUP, 6'd0, 32'h0));
      send_request(make_req(CMD_SPARE_A, 6'd42, 32'h1234_5678));
      send_request(make_req(CMD_SPARE_B, 6'd21, 32'h0));
      send_request(make_req(CMD_SPARE_C, 6'd63, 32'hFFFF_FFFF));
      send_request(make_req(ivd_pkg::CMD_UNREGISTER, 6'd63, 32'h0));
      send_request(make_req(ivd_pkg::CMD_RAISE, 6'd63, 32'h0));
      send_request(make_req(ivd_pkg::CMD_DISPATCH, 6'd0, 32'h0));
   endtask

   task automatic run_random(input int n_items);
      int               issued;
      int               burst;
      logic [LINE_W-1:0] line;
      issued = 0;
      while (issued < n_items) begin
         case ($urandom_range(9))
            0: begin
               // Raise a burst of 12 to 20 lines so that the queue, 16 deep, can fill and overflow.
               burst = $urandom_range(12, 20);
               repeat (burst) begin
                  send_request(make_req(ivd_pkg::CMD_RAISE, rand_line(), rand_addr()));
               end
               issued += burst;
            end
            1: begin
               burst = $urandom_range(4, 18);
               repeat (burst) begin
                  send_request(make_req(ivd_pkg::CMD_DISPATCH, rand_line(), rand_addr()));
               end
               issued += burst;
            end
            2: begin
               // Register a line, raise it and look it up, then send a dispatch, which pops the queue's head line.
               line = rand_line();
               send_request(make_req(ivd_pkg::CMD_REGISTER, line, rand_addr()));
               send_request(make_req(ivd_pkg::CMD_RAISE, line, rand_addr()));
               send_request(make_req(ivd_pkg::CMD_LOOKUP, line, rand_addr()));
               send_request(make_req(ivd_pkg::CMD_DISPATCH, rand_line(), rand_addr()));
               issued += 4;
            end
            default: begin
               send_request(rand_req());
               issued++;
            end
         endcase
         if ($urandom_range(99) == 0) pause_until_drained();
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      pause_until_drained();

      run_random(ITEMS_PER_PHASE);
      pause_until_drained();

      send_idle_pct = 66;
      recv_idle_pct = 20;
      run_random(ITEMS_PER_PHASE);
      pause_until_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(ITEMS_PER_PHASE);

      pause_until_drained();
      repeat (20) @(posedge clock);
      if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
         $display("[irq_vector_dispatcher_core] OK");
      end else begin
         $display("[irq_vector_dispatcher_core] ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[irq_vector_dispatcher_core] ERROR");
      $finish;
   end

endmodule
